/* rtl/ppba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ppba_pkg;

  // Bitmap geometry.
  localparam int PORTS_DEF  = 1024;
  localparam int WORD_BITS  = 32;
  localparam int PAIRS      = WORD_BITS / 2;
  localparam int PAIR_IDX_W = $clog2(PAIRS);

  // Two adjacent bits of one pair.
  localparam logic [WORD_BITS-1:0] PAIR_MASK = 32'h0000_0003;

  // Request codes.
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  // Result of one word search.
  typedef struct packed {
    logic                  hit;
    logic [PAIR_IDX_W-1:0] pair;
  } scan_res_t;

endpackage

`default_nettype wire

/* rtl/ppba_pair_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

// Finds the lowest free pair at or above a start pair in one bitmap word.
module ppba_pair_scan
  import ppba_pkg::*;
(
  input  wire logic [WORD_BITS-1:0]  word,
  input  wire logic [PAIR_IDX_W-1:0] start_pair,
  output scan_res_t                  res
);

  logic [PAIRS-1:0] free_vec;

  // A pair is a candidate when both bits are clear and it lies at or above the start.
  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      free_vec[i] = ~word[2*i] & ~word[2*i+1] & (PAIR_IDX_W'(i) >= start_pair);
    end
  end

  // Priority encoder, lowest index wins.
  always_comb begin
    res = '0;
    for (int i = PAIRS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        res.hit  = 1'b1;
        res.pair = PAIR_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/port_pair_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+-------------------------------------
// in_      | in  | in_valid / in_ready  | in_func (1), in_port (16)
// out_     | out | out_valid / out_ready| out_port_out (16), out_status (2)
// cfg_     | in  | cfg_valid / cfg_ready| cfg_base_port (16)
//
// After reset a clearing pass zeroes the bitmap memory, one word per cycle, PORTS/32
// words in all; input is held off meanwhile, configuration writes are always taken.
// A release runs through accept, read-modify-write, output load, result transfer.
// An allocate runs through accept, then the pair search over k bitmap words
// (1 to PORTS/32 + 1), one search per word read from the single read port, then
// output load and result transfer. A refused request skips the search.
// The block handles one request at a time; a result waits in the output register
// while out_ready is low, and the next request finishes only once it is taken.
module port_pair_bitmap_allocator_unit
  import ppba_pkg::*;
#(
  parameter int PORTS = PORTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_func,
  input  wire logic [15:0] in_port,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_port_out,
  output      logic [1:0]  out_status,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_base_port
);

  localparam int WORDS    = PORTS / WORD_BITS;
  localparam int CAPACITY = WORDS * WORD_BITS;
  localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int NW       = $clog2(WORDS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [WW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [WW-1:0]         wp_r, wp_nxt;
  logic [4:0]            bp_r, bp_nxt;
  logic [CW-1:0]         free_cnt_r, free_cnt_nxt;
  logic [15:0]           base_r, base_nxt;
  logic [WW-1:0]         scan_w_r, scan_w_nxt;
  logic [NW-1:0]         cnt_r, cnt_nxt;
  logic                  first_r, first_nxt;
  logic [PAIR_IDX_W-1:0] rel_p_r, rel_p_nxt;
  logic [15:0]           res_port_r, res_port_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           out_port_r, out_port_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  // Bitmap memory, one write and one registered read port.
  logic [WORD_BITS-1:0]  mem [WORDS];
  logic [WORD_BITS-1:0]  rd_data_r;
  logic [WW-1:0]         rd_addr;
  logic                  mem_we;
  logic [WW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;

  logic                  in_fire;
  logic [16:0]           diff;
  logic                  out_of_range;
  logic [WW-1:0]         nxt_w;
  logic [PAIR_IDX_W-1:0] start_pair;
  scan_res_t             scan;
  logic [WW+4:0]         hit_pos;
  logic [WORD_BITS-1:0]  hit_bits;
  logic [WORD_BITS-1:0]  rel_bits;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_port_out = out_port_r;
  assign out_status   = out_status_r;

  // Release offset; the top bit is the borrow when the port lies below the base.
  assign diff         = {1'b0, in_port} - {1'b0, base_r};
  assign out_of_range = diff[16] || ({1'b0, diff[15:0]} >= 17'(CAPACITY));

  assign nxt_w      = (scan_w_r == WW'(WORDS - 1)) ? '0 : scan_w_r + 1'b1;
  assign start_pair = first_r ? bp_r[4:1] : '0;
  assign hit_pos    = {scan_w_r, scan.pair, 1'b0};
  assign hit_bits   = PAIR_MASK << {scan.pair, 1'b0};
  assign rel_bits   = PAIR_MASK << {rel_p_r, 1'b0};

  ppba_pair_scan u_scan (
    .word       (rd_data_r),
    .start_pair (start_pair),
    .res        (scan)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    wp_nxt         = wp_r;
    bp_nxt         = bp_r;
    free_cnt_nxt   = free_cnt_r;
    base_nxt       = base_r;
    scan_w_nxt     = scan_w_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    rel_p_nxt      = rel_p_r;
    res_port_nxt   = res_port_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_port_nxt   = out_port_r;
    out_status_nxt = out_status_r;
    rd_addr        = wp_r;
    mem_we         = 1'b0;
    mem_waddr      = scan_w_r;
    mem_wdata      = '0;

    if (cfg_valid) begin
      base_nxt = cfg_base_port;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == WW'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_port_nxt = '0;
          if (in_func == FUNC_ALLOC) begin
            if (free_cnt_r < CW'(2)) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              rd_addr    = wp_r;
              scan_w_nxt = wp_r;
              cnt_nxt    = '0;
              first_nxt  = 1'b1;
              state_nxt  = S_SCAN;
            end
          end else begin
            if (out_of_range) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              rd_addr    = diff[WW+4:5];
              scan_w_nxt = diff[WW+4:5];
              rel_p_nxt  = diff[4:1];
              state_nxt  = S_REL;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan.hit) begin
          // Take the pair and move the pointer past it.
          mem_we         = 1'b1;
          mem_wdata      = rd_data_r | hit_bits;
          free_cnt_nxt   = free_cnt_r - CW'(2);
          res_port_nxt   = base_r + 16'(hit_pos);
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          if (scan.pair == PAIR_IDX_W'(PAIRS - 1)) begin
            bp_nxt = '0;
            wp_nxt = nxt_w;
          end else begin
            bp_nxt = {scan.pair + 1'b1, 1'b0};
            wp_nxt = scan_w_r;
          end
        end else if (cnt_r == NW'(WORDS)) begin
          // Full circle without a free pair.
          res_status_nxt = ST_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          rd_addr    = nxt_w;
          scan_w_nxt = nxt_w;
          cnt_nxt    = cnt_r + 1'b1;
          first_nxt  = 1'b0;
        end
      end
      S_REL: begin
        if ((rd_data_r & rel_bits) == '0) begin
          res_status_nxt = ST_FREE;
        end else begin
          mem_we         = 1'b1;
          mem_wdata      = rd_data_r & ~rel_bits;
          free_cnt_nxt   = free_cnt_r + CW'(2);
          res_status_nxt = ST_OK;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_port_nxt   = res_port_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      wp_r        <= '0;
      bp_r        <= '0;
      free_cnt_r  <= CW'(CAPACITY);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      wp_r        <= wp_nxt;
      bp_r        <= bp_nxt;
      free_cnt_r  <= free_cnt_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_w_r     <= scan_w_nxt;
    cnt_r        <= cnt_nxt;
    first_r      <= first_nxt;
    rel_p_r      <= rel_p_nxt;
    res_port_r   <= res_port_nxt;
    res_status_r <= res_status_nxt;
    out_port_r   <= out_port_nxt;
    out_status_r <= out_status_nxt;
  end

  // Bitmap memory access.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  // The free count never exceeds the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CW'(CAPACITY))
    else $error("free count above capacity");

  // The bit pointer always sits on an even position.
  assert property (@(posedge clk) disable iff (!rst_n)
    bp_r[0] == 1'b0)
    else $error("bit pointer odd");

  // The word pointer stays inside the bitmap.
  assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WW'(WORDS - 1))
    else $error("word pointer beyond bitmap");

  // A successful pair search takes exactly two free positions.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan.hit) |=> free_cnt_r == $past(free_cnt_r) - CW'(2))
    else $error("free count not reduced by a pair");

  // A new result is only loaded from the response state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result presented outside response state");
`endif

endmodule

`default_nettype wire
